// ----- rtl/rhc_pkg.sv -----
// Shared types and constants for the RGB to HSV converter.
package rhc_pkg;

  localparam int ChanW     = 8;
  localparam int QuotW     = 8;
  localparam int DivSteps  = QuotW;
  localparam int HueNW     = 11;                   // sextant numerator, below 6*255
  localparam int HueRemW   = HueNW + ChanW;        // numerator times 255
  localparam int HueDenW   = HueNW + DivSteps - 1; // 6*delta aligned to top quotient bit
  localparam int SatRemW   = 2 * ChanW;            // delta times 255
  localparam int SatDenW   = ChanW + DivSteps - 1; // max aligned to top quotient bit

  typedef enum logic [1:0] {
    MAX_RED,
    MAX_GREEN,
    MAX_BLUE
  } max_sel_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [ChanW-1:0] hue;
    logic [ChanW-1:0] saturation;
    logic [ChanW-1:0] brightness;
  } hsv_t;

  // after max/min search
  typedef struct packed {
    pixel_t           px;
    logic [ChanW-1:0] mx;
    logic [ChanW-1:0] mn;
    max_sel_t         sel;
  } ext_t;

  // after sextant numerator
  typedef struct packed {
    logic [HueNW-1:0] num;
    logic [ChanW-1:0] delta;
    logic [ChanW-1:0] mx;
  } sext_t;

  // divider operands, one quotient bit resolved per stage
  typedef struct packed {
    logic [HueRemW-1:0] hue_rem;
    logic [HueDenW-1:0] hue_den;
    logic [QuotW-1:0]   hue_q;
    logic [SatRemW-1:0] sat_rem;
    logic [SatDenW-1:0] sat_den;
    logic [QuotW-1:0]   sat_q;
    logic               grey;
    logic [ChanW-1:0]   bright;
  } div_t;

endpackage

// ----- rtl/rhc_front.sv -----
// Front stages: max/min search, sextant numerator, divider operand setup.
module rhc_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  rhc_pkg::pixel_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output rhc_pkg::div_t   out_data
);

  logic             a_vld_r, b_vld_r, c_vld_r;
  logic             a_rdy, b_rdy, c_rdy;
  rhc_pkg::ext_t    a_r, a_nxt;
  rhc_pkg::sext_t   b_r, b_nxt;
  rhc_pkg::div_t    c_r, c_nxt;

  logic [rhc_pkg::ChanW-1:0] delta;
  logic [rhc_pkg::HueNW-1:0] six_d;
  logic [rhc_pkg::HueNW:0]   num_wide;
  logic [rhc_pkg::HueNW-1:0] six_d_c;

  assign c_rdy = !c_vld_r || out_ready;
  assign b_rdy = !b_vld_r || c_rdy;
  assign a_rdy = !a_vld_r || b_rdy;
  assign in_ready = a_rdy;

  // stage A: largest and smallest channel, red over green over blue on ties
  always_comb begin
    a_nxt.px = in_data;
    if (in_data.red >= in_data.green && in_data.red >= in_data.blue) begin
      a_nxt.sel = rhc_pkg::MAX_RED;
      a_nxt.mx  = in_data.red;
    end else if (in_data.green >= in_data.blue) begin
      a_nxt.sel = rhc_pkg::MAX_GREEN;
      a_nxt.mx  = in_data.green;
    end else begin
      a_nxt.sel = rhc_pkg::MAX_BLUE;
      a_nxt.mx  = in_data.blue;
    end
    a_nxt.mn = in_data.blue;
    if (in_data.green < a_nxt.mn) a_nxt.mn = in_data.green;
    if (in_data.red < a_nxt.mn) a_nxt.mn = in_data.red;
  end

  // stage B: hue numerator in units of 60/delta degrees, range 0..6*delta-1
  always_comb begin
    delta = a_r.mx - a_r.mn;
    six_d = {1'b0, delta, 2'b00} + {2'b00, delta, 1'b0};
    case (a_r.sel)
      rhc_pkg::MAX_RED: begin
        num_wide = {1'b0, six_d} + {4'b0000, a_r.px.green} - {4'b0000, a_r.px.blue};
        if (a_r.px.green >= a_r.px.blue)
          num_wide = {4'b0000, a_r.px.green} - {4'b0000, a_r.px.blue};
      end
      rhc_pkg::MAX_GREEN:
        num_wide = {3'b000, delta, 1'b0} + {4'b0000, a_r.px.blue} - {4'b0000, a_r.px.red};
      rhc_pkg::MAX_BLUE:
        num_wide = {2'b00, delta, 2'b00} + {4'b0000, a_r.px.red} - {4'b0000, a_r.px.green};
      default:
        num_wide = '0;
    endcase
    b_nxt.num   = num_wide[rhc_pkg::HueNW-1:0];
    b_nxt.delta = delta;
    b_nxt.mx    = a_r.mx;
  end

  // stage C: numerators times 255, divisors aligned to the top quotient bit
  always_comb begin
    six_d_c       = {1'b0, b_r.delta, 2'b00} + {2'b00, b_r.delta, 1'b0};
    c_nxt.hue_rem = {b_r.num, {rhc_pkg::ChanW{1'b0}}}
                    - {{rhc_pkg::ChanW{1'b0}}, b_r.num};
    c_nxt.hue_den = {six_d_c, {(rhc_pkg::DivSteps-1){1'b0}}};
    c_nxt.hue_q   = '0;
    c_nxt.sat_rem = {b_r.delta, {rhc_pkg::ChanW{1'b0}}}
                    - {{rhc_pkg::ChanW{1'b0}}, b_r.delta};
    c_nxt.sat_den = {b_r.mx, {(rhc_pkg::DivSteps-1){1'b0}}};
    c_nxt.sat_q   = '0;
    c_nxt.grey    = (b_r.delta == '0);
    c_nxt.bright  = b_r.mx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      if (a_rdy) a_vld_r <= in_valid;
      if (b_rdy) b_vld_r <= a_vld_r;
      if (c_rdy) c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && in_valid) a_r <= a_nxt;
    if (b_rdy && a_vld_r) b_r <= b_nxt;
    if (c_rdy && b_vld_r) c_r <= c_nxt;
  end

  assign out_valid = c_vld_r;
  assign out_data  = c_r;

endmodule

// ----- rtl/rhc_div_stage.sv -----
// One restoring-division step for hue and saturation, one quotient bit each.
module rhc_div_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rhc_pkg::div_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rhc_pkg::div_t out_data
);

  logic          vld_r;
  rhc_pkg::div_t data_r, data_nxt;
  logic          hue_ge, sat_ge;

  assign in_ready = !vld_r || out_ready;

  always_comb begin
    data_nxt = in_data;
    hue_ge   = in_data.hue_rem >= {1'b0, in_data.hue_den};
    sat_ge   = in_data.sat_rem >= {1'b0, in_data.sat_den};
    if (hue_ge) data_nxt.hue_rem = in_data.hue_rem - {1'b0, in_data.hue_den};
    if (sat_ge) data_nxt.sat_rem = in_data.sat_rem - {1'b0, in_data.sat_den};
    // move the divisor down to the next quotient bit
    data_nxt.hue_den = in_data.hue_den >> 1;
    data_nxt.sat_den = in_data.sat_den >> 1;
    data_nxt.hue_q   = {in_data.hue_q[rhc_pkg::QuotW-2:0], hue_ge};
    data_nxt.sat_q   = {in_data.sat_q[rhc_pkg::QuotW-2:0], sat_ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) data_r <= data_nxt;
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule

// ----- rtl/rgb_to_hsv_converter.sv -----
// Top level of the RGB to HSV converter: front stages, divider pipeline, output register.
//
// Converts one 8-bit RGB pixel per transfer into hue, saturation and brightness bytes.
// Input channel: in_valid / in_ready / in_pixel (red, green, blue).
// Result channel: out_valid / out_ready / out_hsv (hue, saturation, brightness).
// Brightness is the largest channel, saturation floor(delta*255/max), hue the sextant
// angle scaled by 255/360 with truncation; a grey pixel gives hue 0 and saturation 0.
// Pipeline: the input transfer loads the first of twelve stages: three front stages
// (max/min, sextant numerator, operand setup), eight divider stages resolving one
// quotient bit each for hue and saturation, one output register.
// Throughput: one pixel per cycle while out_ready is high; every stage carries its own valid bit.
// When out_ready is low, items pack into empty stages and then hold; in_ready
// drops once every stage is full, and nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline: all valid bits clear,
// out_valid goes low and in_ready is high in the first cycle after reset.
module rgb_to_hsv_converter (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  rhc_pkg::pixel_t in_pixel,
  output logic            out_valid,
  input  logic            out_ready,
  output rhc_pkg::hsv_t   out_hsv
);

  logic          vld   [rhc_pkg::DivSteps+1];
  logic          rdy   [rhc_pkg::DivSteps+1];
  rhc_pkg::div_t data  [rhc_pkg::DivSteps+1];

  logic          out_vld_r;
  logic          out_load;
  rhc_pkg::hsv_t out_r, out_nxt;

  rhc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_pixel),
    .out_valid (vld[0]),
    .out_ready (rdy[0]),
    .out_data  (data[0])
  );

  for (genvar i = 0; i < rhc_pkg::DivSteps; i++) begin : g_div
    rhc_div_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vld[i]),
      .in_ready  (rdy[i]),
      .in_data   (data[i]),
      .out_valid (vld[i+1]),
      .out_ready (rdy[i+1]),
      .out_data  (data[i+1])
    );
  end

  assign out_load                 = !out_vld_r || out_ready;
  assign rdy[rhc_pkg::DivSteps]   = out_load;

  always_comb begin
    out_nxt.hue        = data[rhc_pkg::DivSteps].grey ? '0 : data[rhc_pkg::DivSteps].hue_q;
    out_nxt.saturation = data[rhc_pkg::DivSteps].grey ? '0 : data[rhc_pkg::DivSteps].sat_q;
    out_nxt.brightness = data[rhc_pkg::DivSteps].bright;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= vld[rhc_pkg::DivSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && vld[rhc_pkg::DivSteps]) out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_hsv   = out_r;

endmodule

// ----- tb/sv/tb_rgb_to_hsv_converter.sv -----
// Testbench for the RGB to HSV converter: directed corners, a drain pause and a random stream.
`timescale 1ns / 100ps

module tb_rgb_to_hsv_converter;

  localparam int ClkPeriod  = 10;
  localparam int IdleLimit  = 2000;
  localparam int TailCycles = 24;
  localparam int RandPixels = 1800;
  localparam int MaxReports = 20;

  typedef enum int {
    RX_OPEN,
    RX_CHOPPY,
    RX_SLUGGISH
  } rx_mode_e;

  typedef enum int {
    PK_UNIFORM,
    PK_GREYISH,
    PK_TIE,
    PK_EXTREME
  } pix_kind_e;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_ready;
  rhc_pkg::pixel_t in_pixel  = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  rhc_pkg::hsv_t   out_hsv;

  rhc_pkg::hsv_t hsv_expected[$];
  int unsigned   mismatch_count  = 0;
  int unsigned   pixels_sent     = 0;
  int unsigned   results_checked = 0;
  int unsigned   idle_cycles     = 0;

  rgb_to_hsv_converter u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_pixel (in_pixel),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_hsv  (out_hsv)
  );

  initial begin
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // Exact integer HSV of one pixel; red wins ties over green, green over blue.
  function automatic rhc_pkg::hsv_t predict_hsv(rhc_pkg::pixel_t px);
    int unsigned       r, g, b, mx, mn, delta, num;
    rhc_pkg::max_sel_t sel;
    rhc_pkg::hsv_t     res;
    r = px.red;
    g = px.green;
    b = px.blue;
    mx = b;
    mn = b;
    sel = rhc_pkg::MAX_BLUE;
    if (mx < g) begin
      mx = g;
      sel = rhc_pkg::MAX_GREEN;
    end
    if (mx < r) begin
      mx = r;
      sel = rhc_pkg::MAX_RED;
    end
    if (r == mx) sel = rhc_pkg::MAX_RED;
    else if (g == mx) sel = rhc_pkg::MAX_GREEN;
    if (mn > g) mn = g;
    if (mn > r) mn = r;
    delta = mx - mn;
    res.hue        = '0;
    res.saturation = '0;
    res.brightness = 8'(mx);
    if (delta != 0) begin
      res.saturation = 8'((delta * 255) / mx);
      case (sel)
        rhc_pkg::MAX_RED: begin
          // negative angle wraps by a full turn
          if (g >= b) num = 60 * (g - b);
          else num = 360 * delta - 60 * (b - g);
        end
        rhc_pkg::MAX_GREEN: num = 120 * delta + 60 * b - 60 * r;
        default:            num = 240 * delta + 60 * r - 60 * g;
      endcase
      res.hue = 8'((num * 255) / (360 * delta));
    end
    return res;
  endfunction

  // Record each input transfer, then check each output transfer against the oldest prediction.
  always @(posedge clk) begin
    rhc_pkg::hsv_t want;
    if (rst_n && in_valid && in_ready) begin
      hsv_expected.push_back(predict_hsv(in_pixel));
      pixels_sent++;
    end
    if (rst_n && out_valid && out_ready) begin
      results_checked++;
      if (hsv_expected.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports)
          $display("%0t: unexpected result, expected none, actual h=%0d s=%0d v=%0d",
                   $time, out_hsv.hue, out_hsv.saturation, out_hsv.brightness);
      end else begin
        want = hsv_expected.pop_front();
        if (out_hsv.hue !== want.hue) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports)
            $display("%0t: hue mismatch, expected %0d, actual %0d",
                     $time, want.hue, out_hsv.hue);
        end
        if (out_hsv.saturation !== want.saturation) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports)
            $display("%0t: saturation mismatch, expected %0d, actual %0d",
                     $time, want.saturation, out_hsv.saturation);
        end
        if (out_hsv.brightness !== want.brightness) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports)
            $display("%0t: brightness mismatch, expected %0d, actual %0d",
                     $time, want.brightness, out_hsv.brightness);
        end
      end
    end
  end

  // End the run if no transfer happens on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, IdleLimit, hsv_expected.size());
      $display("tb_rgb_to_hsv_converter: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver backpressure: switch between open, choppy and sluggish stretches.
  initial begin
    rx_mode_e    rx_mode;
    int unsigned rx_left;
    rx_mode = RX_OPEN;
    rx_left = 0;
    forever begin
      @(posedge clk);
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 2));
        rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_CHOPPY: out_ready <= 1'($urandom_range(0, 1));
        default:   out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Hold valid and the pixel until the transfer; valid stays high for the caller.
  task automatic send_pixel(rhc_pkg::pixel_t px);
    in_valid <= 1'b1;
    in_pixel <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic idle_sender(int unsigned cycles);
    if (cycles == 0) return;
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Wait for the clock before polling the queue so the last transfer is already recorded.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (hsv_expected.size() != 0) @(posedge clk);
  endtask

  function automatic rhc_pkg::pixel_t make_pixel(int unsigned r, int unsigned g,
                                                 int unsigned b);
    rhc_pkg::pixel_t px;
    px.red   = 8'(r);
    px.green = 8'(g);
    px.blue  = 8'(b);
    return px;
  endfunction

  function automatic logic [7:0] extreme_byte();
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  function automatic rhc_pkg::pixel_t random_pixel();
    pix_kind_e       kind;
    int unsigned     roll, base, spread;
    rhc_pkg::pixel_t px;
    roll = $urandom_range(0, 99);
    if (roll < 60) kind = PK_UNIFORM;
    else if (roll < 75) kind = PK_GREYISH;
    else if (roll < 90) kind = PK_TIE;
    else kind = PK_EXTREME;
    px = rhc_pkg::pixel_t'($urandom());
    case (kind)
      PK_GREYISH: begin
        // near-grey: tiny delta stresses the hue division
        base   = $urandom_range(0, 255);
        spread = $urandom_range(0, 2);
        px.red   = 8'(base > 255 - spread ? 255 : base + $urandom_range(0, spread));
        px.green = 8'(base > 255 - spread ? 255 : base + $urandom_range(0, spread));
        px.blue  = 8'(base > 255 - spread ? 255 : base + $urandom_range(0, spread));
      end
      PK_TIE: begin
        case ($urandom_range(0, 3))
          0:       px.green = px.red;
          1:       px.blue  = px.red;
          2:       px.blue  = px.green;
          default: begin
            px.green = px.red;
            px.blue  = px.red;
          end
        endcase
      end
      PK_EXTREME: begin
        px.red   = extreme_byte();
        px.green = extreme_byte();
        px.blue  = extreme_byte();
      end
      default: ;
    endcase
    return px;
  endfunction

  task automatic test_directed_corners();
    rhc_pkg::pixel_t corners[$];
    corners = '{
      make_pixel(0, 0, 0),       make_pixel(255, 255, 255), make_pixel(128, 128, 128),
      make_pixel(1, 1, 1),       make_pixel(255, 0, 0),     make_pixel(0, 255, 0),
      make_pixel(0, 0, 255),     make_pixel(255, 255, 0),   make_pixel(0, 255, 255),
      make_pixel(255, 0, 255),   make_pixel(255, 0, 1),     make_pixel(200, 10, 100),
      make_pixel(1, 0, 0),       make_pixel(0, 1, 0),       make_pixel(0, 0, 1),
      make_pixel(255, 254, 254), make_pixel(255, 1, 0),     make_pixel(0, 255, 1),
      make_pixel(1, 0, 255),     make_pixel(254, 0, 255),   make_pixel(255, 255, 254),
      make_pixel(170, 85, 255)
    };
    foreach (corners[i]) send_pixel(corners[i]);
    in_valid <= 1'b0;
  endtask

  // Pause the sender until every prediction has been matched, then resume.
  task automatic test_drain_pause();
    repeat (3) begin
      repeat ($urandom_range(10, 40)) send_pixel(random_pixel());
      wait_drained();
    end
  endtask

  task automatic test_random_stream();
    int unsigned burst, sent;
    sent = 0;
    while (sent < RandPixels) begin
      burst = $urandom_range(1, 40);
      repeat (burst) send_pixel(random_pixel());
      sent += burst;
      // roughly a third of the bursts run straight into the next one
      if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 8));
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_corners();
    test_drain_pause();
    test_random_stream();
    wait_drained();
    repeat (TailCycles) @(posedge clk);
    $display("Sent %0d pixels (corners, grey, ties, near-grey, random) and checked %0d results",
             pixels_sent, results_checked);
    $display("with random sender gaps and receiver stalls; %0d field mismatches", mismatch_count);
    if (mismatch_count == 0 && hsv_expected.size() == 0) begin
      $display("tb_rgb_to_hsv_converter: PASS");
    end else begin
      $display("tb_rgb_to_hsv_converter: FAIL");
    end
    $finish;
  end

endmodule
